### hw/rtl/jspd_pkg.sv
// Shared types, constants and the hat lookup of the serial joystick decoder.
// Used by jspd_front, jspd_queue, jspd_back and joystick_serial_packet_decoder.
package jspd_pkg;

    // Framing codes
    localparam logic [7:0] SYNC_BYTE  = 8'h2B;
    localparam logic [7:0] TYPE_LONG  = 8'h01;
    localparam logic [7:0] TYPE_SHORT = 8'h02;

    // Frame lengths, type byte included
    localparam logic [3:0] LEN_LONG  = 4'd10;
    localparam logic [3:0] LEN_SHORT = 4'd6;
    localparam logic [3:0] LEN_NONE  = 4'd0;

    // Frame bytes kept for decoding
    localparam int FIRST_KEPT = 2;
    localparam int LAST_KEPT  = 8;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Raw fields of one complete long frame
    typedef struct packed {
        logic [15:0] axis_x;
        logic [15:0] axis_y;
        logic [7:0]  throttle;
        logic [7:0]  buttons_lo;
        logic [7:0]  hat_byte;
    } t_frame_rec;

    // Queue fill status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    typedef struct packed {
        logic signed [1:0] x;
        logic signed [1:0] y;
    } t_hat;

    // Hat direction from the high nibble; upper half reads as centered
    function automatic t_hat hat_lookup(input logic [3:0] nib);
        t_hat h;
        case (nib)
            4'd0:    begin h.x =  2'sd0; h.y = -2'sd1; end
            4'd1:    begin h.x =  2'sd1; h.y = -2'sd1; end
            4'd2:    begin h.x =  2'sd1; h.y =  2'sd0; end
            4'd3:    begin h.x =  2'sd1; h.y =  2'sd1; end
            4'd4:    begin h.x =  2'sd0; h.y =  2'sd1; end
            4'd5:    begin h.x = -2'sd1; h.y =  2'sd1; end
            4'd6:    begin h.x = -2'sd1; h.y =  2'sd0; end
            4'd7:    begin h.x = -2'sd1; h.y = -2'sd1; end
            default: begin h.x =  2'sd0; h.y =  2'sd0; end
        endcase
        return h;
    endfunction

endpackage

### hw/rtl/jspd_front.sv
// Front end: byte parser that tracks sync, frame type and position, and
// pushes the kept bytes of each complete long frame. Depends on jspd_pkg.
module jspd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_rx_byte,
    input  jspd_pkg::t_queue_stat i_q_stat,
    output logic                  o_stall,
    output logic                  o_push,
    output jspd_pkg::t_frame_rec  o_rec
);

    logic       r_synced, n_synced;
    logic [3:0] r_frame_len, n_frame_len;
    logic [3:0] r_byte_idx, n_byte_idx;
    logic [7:0] r_bytes [jspd_pkg::FIRST_KEPT:jspd_pkg::LAST_KEPT];
    logic       accept;
    logic       wr_en;
    logic       push;

    // Hold off requests only while the queue has no room
    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;

    // Parse one request
    always_comb begin
        n_synced    = r_synced;
        n_frame_len = r_frame_len;
        n_byte_idx  = r_byte_idx;
        wr_en       = 1'b0;
        push        = 1'b0;
        if (accept) begin
            if (!r_synced) begin
                if (i_rx_byte == jspd_pkg::SYNC_BYTE) begin
                    n_synced = 1'b1;
                end
            end else if (r_frame_len == jspd_pkg::LEN_NONE) begin
                // type byte takes frame slot 0
                if (i_rx_byte == jspd_pkg::TYPE_LONG) begin
                    n_frame_len = jspd_pkg::LEN_LONG;
                    n_byte_idx  = 4'd1;
                end else if (i_rx_byte == jspd_pkg::TYPE_SHORT) begin
                    n_frame_len = jspd_pkg::LEN_SHORT;
                    n_byte_idx  = 4'd1;
                end else begin
                    n_synced = 1'b0;
                end
            end else begin
                wr_en = 1'b1;
                if (r_byte_idx + 4'd1 == r_frame_len) begin
                    // frame complete: emit long frames, drop short ones
                    push        = (r_frame_len == jspd_pkg::LEN_LONG);
                    n_synced    = 1'b0;
                    n_frame_len = jspd_pkg::LEN_NONE;
                    n_byte_idx  = 4'd0;
                end else begin
                    n_byte_idx = r_byte_idx + 4'd1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced    <= 1'b0;
            r_frame_len <= jspd_pkg::LEN_NONE;
            r_byte_idx  <= 4'd0;
        end else begin
            r_synced    <= n_synced;
            r_frame_len <= n_frame_len;
            r_byte_idx  <= n_byte_idx;
        end
    end

    // Capture the frame bytes that the decode needs
    always_ff @(posedge i_clk) begin
        for (int k = jspd_pkg::FIRST_KEPT; k <= jspd_pkg::LAST_KEPT; k++) begin
            if (wr_en && r_byte_idx == 4'(k)) begin
                r_bytes[k] <= i_rx_byte;
            end
        end
    end

    assign o_push              = push;
    assign o_rec.axis_x        = {r_bytes[3], r_bytes[2]};
    assign o_rec.axis_y        = {r_bytes[5], r_bytes[4]};
    assign o_rec.throttle      = r_bytes[6];
    assign o_rec.buttons_lo    = r_bytes[7];
    assign o_rec.hat_byte      = r_bytes[8];

    // A frame length is only set while synced
    a_len_needs_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_len != jspd_pkg::LEN_NONE) |-> r_synced)
        else $error("frame length set while not synced");

    // A push ends the frame and drops sync
    a_push_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (!r_synced && r_frame_len == jspd_pkg::LEN_NONE))
        else $error("parser not cleared after frame");

endmodule

### hw/rtl/jspd_queue.sv
// Short queue of complete frame records between front and back.
// Depends on jspd_pkg.
module jspd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  jspd_pkg::t_frame_rec  i_rec,
    input  logic                  i_pop,
    output jspd_pkg::t_frame_rec  o_rec,
    output jspd_pkg::t_queue_stat o_stat
);

    jspd_pkg::t_frame_rec                 r_mem [jspd_pkg::QUEUE_DEPTH];
    logic [jspd_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [jspd_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [jspd_pkg::QUEUE_CNT_W-1:0]     r_count;

    assign o_stat.full  = (r_count == jspd_pkg::QUEUE_CNT_W'(jspd_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rec        = r_mem[r_rd_ptr];

    // Store pushed records
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule

### hw/rtl/jspd_back.sv
// Back end: takes frame records from the queue, decodes hat and buttons,
// and holds the result in the output register. Depends on jspd_pkg.
module jspd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  jspd_pkg::t_frame_rec  i_rec,
    input  jspd_pkg::t_queue_stat i_q_stat,
    input  logic                  i_stall,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic signed [15:0]    o_axis_x,
    output logic signed [15:0]    o_axis_y,
    output logic [7:0]            o_throttle,
    output logic signed [1:0]     o_hat_x,
    output logic signed [1:0]     o_hat_y,
    output logic [8:0]            o_buttons
);

    logic               r_valid;
    logic signed [15:0] r_axis_x;
    logic signed [15:0] r_axis_y;
    logic [7:0]         r_throttle;
    logic signed [1:0]  r_hat_x;
    logic signed [1:0]  r_hat_y;
    logic [8:0]         r_buttons;
    logic               pop;
    jspd_pkg::t_hat     hat;

    // Load when the output register is free or being taken
    assign pop = !i_q_stat.empty && (!r_valid || !i_stall);
    assign hat = jspd_pkg::hat_lookup(i_rec.hat_byte[7:4]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Decode into the output register
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_axis_x   <= i_rec.axis_x;
            r_axis_y   <= i_rec.axis_y;
            r_throttle <= i_rec.throttle;
            r_hat_x    <= hat.x;
            r_hat_y    <= hat.y;
            r_buttons  <= {i_rec.hat_byte[0], i_rec.buttons_lo};
        end
    end

    assign o_pop      = pop;
    assign o_valid    = r_valid;
    assign o_axis_x   = r_axis_x;
    assign o_axis_y   = r_axis_y;
    assign o_throttle = r_throttle;
    assign o_hat_x    = r_hat_x;
    assign o_hat_y    = r_hat_y;
    assign o_buttons  = r_buttons;

    // A waiting record always moves out once the output register frees up
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_q_stat.empty && !r_valid) |=> r_valid)
        else $error("queued record not loaded");

endmodule

### hw/rtl/joystick_serial_packet_decoder.sv
// Top level of the serial joystick frame decoder.
// Depends on jspd_pkg, jspd_front, jspd_queue and jspd_back.

// The decoder takes one received byte per cycle while o_stall is low,
// hunts for the sync byte 0x2B, reads the type byte after it and collects
// a 10-byte (type 1) or 6-byte (type 2) frame; any other type drops back
// to hunting. Each complete type-1 frame yields one result with stick X/Y,
// throttle, nine buttons and hat direction; type-2 frames produce nothing.
// Each result is pushed into the record queue and then loaded into the
// output register. The parser, the two-entry record queue and the output
// register run decoupled, so o_stall rises only when that queue is full,
// which takes a downstream stall across several whole frames.
module joystick_serial_packet_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_rx_byte,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_axis_x,
    output logic signed [15:0] o_axis_y,
    output logic [7:0]         o_throttle,
    output logic signed [1:0]  o_hat_x,
    output logic signed [1:0]  o_hat_y,
    output logic [8:0]         o_buttons
);

    jspd_pkg::t_queue_stat q_stat;
    jspd_pkg::t_frame_rec  push_rec;
    jspd_pkg::t_frame_rec  pop_rec;
    logic                  push;
    logic                  pop;

    jspd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_q_stat  (q_stat),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_rec     (push_rec)
    );

    jspd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (pop_rec),
        .o_stat  (q_stat)
    );

    jspd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (pop_rec),
        .i_q_stat   (q_stat),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_axis_x   (o_axis_x),
        .o_axis_y   (o_axis_y),
        .o_throttle (o_throttle),
        .o_hat_x    (o_hat_x),
        .o_hat_y    (o_hat_y),
        .o_buttons  (o_buttons)
    );

endmodule
